// ===== hdl/pprm_pkg.sv =====
// Shared types and constants for the per-pixel running mean block.
package pprm_pkg;

   localparam int CHAN_BITS  = 16;
   localparam int TOTAL_BITS = 24;
   localparam int COORD_BITS = 8;
   localparam int CSR_BITS   = 9;
   localparam int CSR_IDX_BITS = 1;
   localparam int DIV_STEPS  = CHAN_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);
   localparam int LANES      = 3;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_COUNT_BITS = 24;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_WIDTH = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_COUNT = 1'b1;

   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [COORD_BITS-1:0] pixel_column;
      logic [COORD_BITS-1:0] pixel_row;
      logic [CHAN_BITS-1:0]  sample_red;
      logic [CHAN_BITS-1:0]  sample_green;
      logic [CHAN_BITS-1:0]  sample_blue;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]  mean_red;
      logic [CHAN_BITS-1:0]  mean_green;
      logic [CHAN_BITS-1:0]  mean_blue;
      logic [TOTAL_BITS-1:0] sample_total;
      logic                  bad_coordinate;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic addr;
      logic read;
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic bad;
      logic read_item;
      logic div_last;
      logic out_full;
   } status_type;

endpackage

// ===== hdl/per_pixel_running_mean.sv =====
// Top level of the per-pixel running mean block.
// Keeps a running mean RGB color (unsigned 8.8) and a saturating sample count for every
// pixel; an add request moves each channel mean by (sample - mean) / new count, truncated
// toward zero, and a read request returns the stored mean and count. After reset the block
// sweeps both stores to zero, one pixel per cycle, over all MAX_WIDTH * MAX_HEIGHT pixels
// (65536 at the defaults), during which req_ready stays low; size registers can be written
// throughout. Requests are handled one at a time: an add runs the address multiply, store
// read, divider load, the 16 restoring divide steps of the three channel lanes (each with
// its own divider, sharing the divisor and step counter) and response load with write back;
// a read or an off-image request takes only address multiply, store read and response load.
// A finished response waits in the output register, and the next request is taken while it waits.
module per_pixel_running_mean #(
   parameter int MAX_WIDTH  = pprm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = pprm_pkg::DEF_MAX_HEIGHT,
   parameter int COUNT_BITS = pprm_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pprm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pprm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [pprm_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [pprm_pkg::CSR_BITS-1:0]     csr_data
);
   import pprm_pkg::*;

   cmd_type    cmd;
   status_type status;

   pprm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pprm_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/pprm_ctrl.sv =====
// Sequencer for the per-pixel running mean: clearing sweep, lookup, divide, write back.
module pprm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pprm_pkg::status_type status,
   output pprm_pkg::cmd_type    cmd
);
   import pprm_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ADDR   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_LOAD   = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.addr = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            // off-image and read requests need no division
            if (status.bad || status.read_item) state_in = S_FINISH;
            else state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!status.out_full) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ===== hdl/pprm_datapath.sv =====
// Datapath: size registers, pixel stores, three divider lanes and the response register.
module pprm_datapath #(
   parameter int MAX_WIDTH  = pprm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = pprm_pkg::DEF_MAX_HEIGHT,
   parameter int COUNT_BITS = pprm_pkg::DEF_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pprm_pkg::cmd_type                   cmd,
   output pprm_pkg::status_type                status,
   input  pprm_pkg::req_type                   req_data,
   input  logic                                csr_write,
   input  logic [pprm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [pprm_pkg::CSR_BITS-1:0]       csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pprm_pkg::rsp_type                   rsp_data
);
   import pprm_pkg::*;

   localparam int PIXELS    = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int PROD_BITS = COORD_BITS + CSR_BITS;
   localparam int CMP_BITS  = 33;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [ADDR_BITS-1:0]  LAST_ADDR = ADDR_BITS'(PIXELS - 1);

   // configuration
   logic [CSR_BITS-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_BITS'(256);
         height_ff <= CSR_BITS'(256);
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROW_WIDTH: width_ff  <= csr_data;
            CSR_ROW_COUNT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // request capture and address
   req_type              req_ff;
   logic                 bad_ff, bad_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [CSR_BITS-1:0]  w_lim, h_lim;
   logic [PROD_BITS-1:0] prod;
   logic [31:0]          addr_wide;

   always_comb begin
      w_lim = (32'(width_ff) > MAX_WIDTH) ? CSR_BITS'(MAX_WIDTH) : width_ff;
      h_lim = (32'(height_ff) > MAX_HEIGHT) ? CSR_BITS'(MAX_HEIGHT) : height_ff;
      bad_in = ({1'b0, req_ff.pixel_column} >= w_lim) ||
               ({1'b0, req_ff.pixel_row} >= h_lim);
      prod = PROD_BITS'(req_ff.pixel_row) * PROD_BITS'(w_lim) +
             PROD_BITS'(req_ff.pixel_column);
      addr_wide = (32'(prod) >= PIXELS) ? 32'(PIXELS - 1) : 32'(prod);
      addr_in = ADDR_BITS'(addr_wide);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.addr) begin
         addr_ff <= addr_in;
         bad_ff  <= bad_in;
      end
   end

   // pixel stores
   logic [COUNT_BITS-1:0]               count_mem [PIXELS];
   logic [LANES*CHAN_BITS-1:0]          mean_mem  [PIXELS];
   logic [COUNT_BITS-1:0]               rd_count_ff;
   logic [LANES-1:0][CHAN_BITS-1:0]     rd_mean_ff;
   logic [ADDR_BITS-1:0]                clr_ff;
   logic                                mem_we;
   logic [ADDR_BITS-1:0]                wr_addr;
   logic [COUNT_BITS-1:0]               wr_count;
   logic [LANES-1:0][CHAN_BITS-1:0]     wr_mean;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[wr_addr] <= wr_count;
         mean_mem[wr_addr]  <= wr_mean;
      end
      if (cmd.read) begin
         rd_count_ff <= count_mem[addr_ff];
         rd_mean_ff  <= mean_mem[addr_ff];
      end
   end

   // divider lanes: restoring, one quotient bit per step
   logic [COUNT_BITS-1:0]            n_ff;
   logic [LANES-1:0][CHAN_BITS-1:0]  mag_ff, rem_ff;
   logic [LANES-1:0]                 neg_ff;
   logic [STEP_BITS-1:0]             step_ff;
   logic [LANES-1:0][CHAN_BITS-1:0]  smp;
   logic [LANES-1:0][CHAN_BITS:0]    diff;
   logic [LANES-1:0][CHAN_BITS:0]    trial;
   logic [LANES-1:0]                 fits;
   logic [LANES-1:0][CHAN_BITS-1:0]  new_mean;

   assign smp[0] = req_ff.sample_red;
   assign smp[1] = req_ff.sample_green;
   assign smp[2] = req_ff.sample_blue;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         diff[i]  = {1'b0, smp[i]} - {1'b0, rd_mean_ff[i]};
         trial[i] = {rem_ff[i], mag_ff[i][CHAN_BITS-1]};
         fits[i]  = CMP_BITS'(trial[i]) >= CMP_BITS'(n_ff);
         new_mean[i] = neg_ff[i] ? (rd_mean_ff[i] - mag_ff[i]) :
                                   (rd_mean_ff[i] + mag_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff    <= (rd_count_ff == COUNT_MAX) ? rd_count_ff : rd_count_ff + 1'b1;
         step_ff <= '0;
         for (int i = 0; i < LANES; i++) begin
            neg_ff[i] <= diff[i][CHAN_BITS];
            mag_ff[i] <= diff[i][CHAN_BITS] ? CHAN_BITS'(-diff[i]) : diff[i][CHAN_BITS-1:0];
            rem_ff[i] <= '0;
         end
      end else if (cmd.step) begin
         step_ff <= step_ff + 1'b1;
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= fits[i] ? CHAN_BITS'(CMP_BITS'(trial[i]) - CMP_BITS'(n_ff))
                                 : trial[i][CHAN_BITS-1:0];
            mag_ff[i] <= {mag_ff[i][CHAN_BITS-2:0], fits[i]};
         end
      end
   end

   // write back and response
   logic    add_item;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic [31:0] n_wide, rd_wide;

   assign add_item = (req_ff.func == FUNC_ADD) && !bad_ff;
   assign n_wide   = 32'(n_ff);
   assign rd_wide  = 32'(rd_count_ff);

   always_comb begin
      mem_we   = cmd.clear || (cmd.finish && add_item);
      wr_addr  = cmd.clear ? clr_ff : addr_ff;
      wr_count = cmd.clear ? '0 : n_ff;
      wr_mean  = cmd.clear ? '0 : new_mean;

      rsp_in = '0;
      if (bad_ff) begin
         rsp_in.bad_coordinate = 1'b1;
      end else if (req_ff.func == FUNC_READ) begin
         rsp_in.mean_red     = rd_mean_ff[0];
         rsp_in.mean_green   = rd_mean_ff[1];
         rsp_in.mean_blue    = rd_mean_ff[2];
         rsp_in.sample_total = rd_wide[TOTAL_BITS-1:0];
      end else begin
         rsp_in.mean_red     = new_mean[0];
         rsp_in.mean_green   = new_mean[1];
         rsp_in.mean_blue    = new_mean[2];
         rsp_in.sample_total = n_wide[TOTAL_BITS-1:0];
      end

      if (cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.clear_last = (clr_ff == LAST_ADDR);
      status.bad        = bad_ff;
      status.read_item  = (req_ff.func == FUNC_READ);
      status.div_last   = (step_ff == STEP_BITS'(DIV_STEPS - 1));
      status.out_full   = rsp_valid_ff && !rsp_ready;
   end

endmodule
